### src/ebre_pkg.sv
// ----------------------------------------------------------------------------
// ebre_pkg
// Shared types, widths and fixed filter coefficients of the EMG band-pass,
// rectify and envelope block.
// ----------------------------------------------------------------------------
`default_nettype none

package ebre_pkg;

  localparam int NCH            = 4;
  localparam int NZ             = 8;
  localparam int X_W            = 16;
  localparam int COEF_W         = 27;
  localparam int DEN_W          = 31;
  localparam int Z_W            = 48;
  localparam int Y_W            = 34;
  localparam int BAND_W         = 26;
  localparam int LEVEL_W        = 25;
  localparam int WINDOW_LEN_DEF = 128;
  localparam int AVG_TAPS_DEF   = 32;

  localparam logic signed [COEF_W-1:0] NUM_Q27 [9] = '{
    27'sd8543377, 27'sd0, -27'sd34173507, 27'sd0, 27'sd51260261,
    27'sd0, -27'sd34173507, 27'sd0, 27'sd8543377
  };

  localparam logic signed [DEN_W-1:0] DEN_Q27 [9] = '{
    31'sd134217728, -31'sd497391384, 31'sd796392639, -31'sd783139516,
    31'sd570252074, -31'sd306540360, 31'sd104311010, -31'sd20792228,
    31'sd2919298
  };

  localparam logic signed [COEF_W-1:0] TMPL_Q27 [NZ] = '{
    -27'sd8543377, -27'sd8543377, 27'sd25630130, 27'sd25630130,
    -27'sd25630130, -27'sd25630130, 27'sd8543377, 27'sd8543377
  };

  typedef logic signed [X_W-1:0] sample_t;

  typedef struct packed {
    logic load;
    logic pre;
    logic ycalc;
    logic mul;
    logic upd;
    logic div1;
    logic div2;
    logic div3;
    logic primed;
    logic win_start;
  } ebre_ctl_t;

  typedef struct packed {
    logic signed [BAND_W-1:0] band;
    logic [LEVEL_W-1:0]       level;
  } lane_res_t;

endpackage

`default_nettype wire

### src/ebre_in_if.sv
// ----------------------------------------------------------------------------
// ebre_in_if
// Input channel: one word of four signed converter samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebre_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_ch0;
  logic signed [15:0] sample_ch1;
  logic signed [15:0] sample_ch2;
  logic signed [15:0] sample_ch3;

  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  input ready);
  modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                output ready);
endinterface

`default_nettype wire

### src/ebre_out_if.sv
// ----------------------------------------------------------------------------
// ebre_out_if
// Output channel: band-pass outputs, envelope levels and the window flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebre_out_if;
  logic               valid;
  logic               ready;
  logic signed [25:0] band_ch0;
  logic signed [25:0] band_ch1;
  logic signed [25:0] band_ch2;
  logic signed [25:0] band_ch3;
  logic [24:0]        level_ch0;
  logic [24:0]        level_ch1;
  logic [24:0]        level_ch2;
  logic [24:0]        level_ch3;
  logic               window_end;

  modport source (output valid, band_ch0, band_ch1, band_ch2, band_ch3,
                  level_ch0, level_ch1, level_ch2, level_ch3, window_end,
                  input ready);
  modport sink (input valid, band_ch0, band_ch1, band_ch2, band_ch3,
                level_ch0, level_ch1, level_ch2, level_ch3, window_end,
                output ready);
endinterface

`default_nettype wire

### src/ebre_lane.sv
// ----------------------------------------------------------------------------
// ebre_lane
// One channel: transposed band-pass filter, rectifier, moving-average ring
// and the reciprocal divider that forms the envelope level.
// ----------------------------------------------------------------------------
`default_nettype none

module ebre_lane import ebre_pkg::*; #(
  parameter int AVG_TAPS = AVG_TAPS_DEF,
  parameter int PW       = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ebre_ctl_t ctl,
  input  wire logic [PW-1:0] pos,
  input  wire sample_t   sample,
  output lane_res_t      res
);

  localparam int SUM_W = LEVEL_W + $clog2(AVG_TAPS);
  localparam int S2W   = SUM_W + 1;
  localparam logic [S2W:0]   RECIP = (S2W+1)'((64'd1 << S2W) / AVG_TAPS);
  localparam logic [S2W-1:0] TAPS  = S2W'(AVG_TAPS);
  localparam logic [S2W-1:0] HALF  = S2W'(AVG_TAPS / 2);

  sample_t                    x;
  logic signed [Z_W-1:0]      z  [NZ];
  logic signed [30:0]         p0;
  logic signed [30:0]         nx [NZ];
  logic signed [Y_W-1:0]      y;
  logic signed [37:0]         dy [NZ];
  logic signed [BAND_W-1:0]   band;
  logic [LEVEL_W-1:0]         rect;
  logic [LEVEL_W-1:0]         ring [AVG_TAPS];
  logic [LEVEL_W-1:0]         rd;
  logic [AVG_TAPS-1:0]        vld;
  logic [SUM_W-1:0]           sum;
  logic [2*S2W:0]             qm;
  logic [S2W-1:0]             qe;
  logic [S2W-1:0]             qt;
  logic [LEVEL_W-1:0]         level;

  logic signed [Z_W-1:0]      z_pre  [NZ];
  logic signed [30:0]         nx_c   [NZ];
  logic signed [37:0]         dy_c   [NZ];
  logic signed [Z_W-1:0]      z_upd  [NZ];
  logic signed [30:0]         p0_c;
  logic signed [Y_W-1:0]      y_c;
  logic signed [BAND_W-1:0]   band_c;
  logic [LEVEL_W-1:0]         rect_c;
  logic [LEVEL_W-1:0]         old;
  logic [S2W-1:0]             s2;
  logic [S2W-1:0]             rem;

  always_comb begin
    logic signed [42:0] tp;
    logic signed [48:0] ys;
    logic signed [34:0] tb;
    logic signed [26:0] br;
    logic signed [26:0] mg;
    tp   = 43'(NUM_Q27[0]) * 43'(x);
    p0_c = 31'((tp + 43'sd1024) >>> 11);
    ys   = 49'(p0) + 49'(z[0]);
    if (ys > 49'sd8589934591) begin
      y_c = 34'sd8589934591;
    end else if (ys < -49'sd8589934592) begin
      y_c = -34'sd8589934592;
    end else begin
      y_c = 34'(ys);
    end
    tb = (35'(y) + 35'sd128) >>> 8;
    br = 27'(tb);
    if (br > 27'sd33554431) begin
      band_c = 26'sd33554431;
    end else if (br < -27'sd33554432) begin
      band_c = -26'sd33554432;
    end else begin
      band_c = 26'(br);
    end
    mg = (band_c < 0) ? -27'(band_c) : 27'(band_c);
    rect_c = (mg > 27'sd33554431) ? 25'd33554431 : 25'(mg);
    old = vld[pos] ? rd : '0;
    s2  = S2W'(sum) + HALF;
    rem = s2 - qt;
  end

  for (genvar i = 0; i < NZ; i++) begin : g_tap
    always_comb begin
      logic signed [42:0] tt;
      logic signed [42:0] tn;
      logic signed [64:0] td;
      logic signed [49:0] acc;
      tt = 43'(TMPL_Q27[i]) * 43'(x);
      z_pre[i] = Z_W'((tt + 43'sd1024) >>> 11);
      tn = 43'(NUM_Q27[i+1]) * 43'(x);
      nx_c[i] = 31'((tn + 43'sd1024) >>> 11);
      td = 65'(DEN_Q27[i+1]) * 65'(y);
      dy_c[i] = 38'((td + (65'sd1 <<< 26)) >>> 27);
      acc = 50'(nx[i]) - 50'(dy[i]);
      if (i + 1 < NZ) begin
        acc = acc + 50'(z[(i + 1) % NZ]);
      end
      if (acc > 50'sd140737488355327) begin
        z_upd[i] = 48'sd140737488355327;
      end else if (acc < -50'sd140737488355328) begin
        z_upd[i] = -48'sd140737488355328;
      end else begin
        z_upd[i] = 48'(acc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pre) begin
      rd <= ring[pos];
    end
    if (ctl.upd) begin
      ring[pos] <= rect;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= sample;
    end
    if (ctl.pre) begin
      if (!ctl.primed) begin
        z <= z_pre;
      end
      p0 <= p0_c;
      nx <= nx_c;
    end
    if (ctl.ycalc) begin
      y <= y_c;
    end
    if (ctl.mul) begin
      dy   <= dy_c;
      band <= band_c;
      rect <= rect_c;
    end
    if (ctl.upd) begin
      z <= z_upd;
    end
    if (ctl.div1) begin
      qm <= (2*S2W+1)'(s2) * (2*S2W+1)'(RECIP);
    end
    if (ctl.div2) begin
      qe <= qm[S2W +: S2W];
      qt <= S2W'(qm[S2W +: S2W] * TAPS);
    end
    if (ctl.div3) begin
      level <= (rem >= TAPS) ? LEVEL_W'(qe + 1'b1) : LEVEL_W'(qe);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      sum <= '0;
    end else if (ctl.pre && ctl.win_start) begin
      vld <= '0;
      sum <= '0;
    end else if (ctl.upd) begin
      vld[pos] <= 1'b1;
      sum      <= sum - SUM_W'(old) + SUM_W'(rect);
    end
  end

  assign res.band  = band;
  assign res.level = level;

endmodule

`default_nettype wire

### src/ebre_merge.sv
// ----------------------------------------------------------------------------
// ebre_merge
// Gathers the four lane results and the window flag into one output word
// and holds it until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ebre_merge import ebre_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire lane_res_t res [NCH],
  input  wire logic      wend,
  output logic           can_load,
  ebre_out_if.source     out
);

  assign can_load = !out.valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (load) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out.band_ch0   <= res[0].band;
      out.band_ch1   <= res[1].band;
      out.band_ch2   <= res[2].band;
      out.band_ch3   <= res[3].band;
      out.level_ch0  <= res[0].level;
      out.level_ch1  <= res[1].level;
      out.level_ch2  <= res[2].level;
      out.level_ch3  <= res[3].level;
      out.window_end <= wend;
    end
  end

endmodule

`default_nettype wire

### src/emg_bandpass_rectify_envelope.sv
// ----------------------------------------------------------------------------
// emg_bandpass_rectify_envelope
// Four-channel EMG band-pass filter, rectifier and windowed moving-average
// envelope, one lane per channel.
// ----------------------------------------------------------------------------
// Each accepted word of four samples gives one result word. A word passes
// from acceptance to the output register through the preload and feed-
// forward products, the output sum, the feedback products, the state update,
// the steps of the reciprocal divider that forms the average, and the
// hand-over to the output register. A new word is accepted only after the
// previous one has moved into the output register, and that hand-over waits
// while the sink has not taken the last result. The first word after reset
// preloads the filter state from its samples; the envelope ring restarts at
// every WINDOW_LEN-th word.
`default_nettype none

module emg_bandpass_rectify_envelope import ebre_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int AVG_TAPS   = AVG_TAPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ebre_in_if.sink   smp,
  ebre_out_if.source res
);

  localparam int PW = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
  localparam int WW = $clog2(WINDOW_LEN);
  localparam logic [PW-1:0] POS_LAST = PW'(AVG_TAPS - 1);
  localparam logic [WW-1:0] WIN_LAST = WW'(WINDOW_LEN - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_Y, S_MUL, S_UPD, S_DV1, S_DV2, S_DV3, S_OUT
  } state_t;

  state_t          state;
  logic            primed;
  logic [PW-1:0]   ring_pos;
  logic [WW-1:0]   window_pos;
  logic            wend;
  ebre_ctl_t       ctl;
  lane_res_t       lane_res [NCH];
  sample_t         lane_x   [NCH];
  logic            can_load;
  logic            load;

  assign smp.ready = (state == S_IDLE);
  assign load      = (state == S_OUT) && can_load;

  assign lane_x[0] = smp.sample_ch0;
  assign lane_x[1] = smp.sample_ch1;
  assign lane_x[2] = smp.sample_ch2;
  assign lane_x[3] = smp.sample_ch3;

  always_comb begin
    ctl           = '0;
    ctl.load      = smp.valid && smp.ready;
    ctl.pre       = (state == S_PRE);
    ctl.ycalc     = (state == S_Y);
    ctl.mul       = (state == S_MUL);
    ctl.upd       = (state == S_UPD);
    ctl.div1      = (state == S_DV1);
    ctl.div2      = (state == S_DV2);
    ctl.div3      = (state == S_DV3);
    ctl.primed    = primed;
    ctl.win_start = (window_pos == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      primed     <= 1'b0;
      ring_pos   <= '0;
      window_pos <= '0;
      wend       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (smp.valid) begin
            state <= S_PRE;
          end
        end
        S_PRE: begin
          primed <= 1'b1;
          state  <= S_Y;
        end
        S_Y:   state <= S_MUL;
        S_MUL: state <= S_UPD;
        S_UPD: begin
          wend <= (window_pos == WIN_LAST);
          if (window_pos == WIN_LAST) begin
            window_pos <= '0;
            ring_pos   <= '0;
          end else begin
            window_pos <= window_pos + 1'b1;
            ring_pos   <= (ring_pos == POS_LAST) ? '0 : ring_pos + 1'b1;
          end
          state <= S_DV1;
        end
        S_DV1: state <= S_DV2;
        S_DV2: state <= S_DV3;
        S_DV3: state <= S_OUT;
        S_OUT: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    ebre_lane #(
      .AVG_TAPS (AVG_TAPS),
      .PW       (PW)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .pos    (ring_pos),
      .sample (lane_x[c]),
      .res    (lane_res[c])
    );
  end

  ebre_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .res      (lane_res),
    .wend     (wend),
    .can_load (can_load),
    .out      (res)
  );

  a_primed_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(primed) && !$past(rst) |-> primed)
    else $error("primed flag dropped");

  a_window_range: assert property (@(posedge clk) disable iff (rst)
    32'(window_pos) < WINDOW_LEN)
    else $error("window position out of range");

  a_ring_range: assert property (@(posedge clk) disable iff (rst)
    32'(ring_pos) < AVG_TAPS)
    else $error("ring position out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |=> res.valid)
    else $error("result word not presented after load");

endmodule

`default_nettype wire
